// File: hw/rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; every other RTL module imports this package.
package wsd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned OpcW  = 4;
  localparam int unsigned EvW   = 2;
  localparam int unsigned LenW  = 64;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned CntW  = 4;

  // Result event codes.
  localparam logic [EvW-1:0] EV_DATA  = 2'd0;
  localparam logic [EvW-1:0] EV_EMPTY = 2'd1;
  localparam logic [EvW-1:0] EV_CLOSE = 2'd2;
  localparam logic [EvW-1:0] EV_ERROR = 2'd3;

  // Input item kinds.
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REOPEN = 1'b1;

  localparam logic [OpcW-1:0] OPC_CLOSE = 4'h8;

  // Seven-bit length field: values up to LEN7_MAX are the length itself.
  localparam logic [6:0] LEN7_MAX   = 7'd125;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;

  localparam logic [CntW-1:0] CNT_EXT16 = 4'd2;
  localparam logic [CntW-1:0] CNT_EXT64 = 4'd8;
  localparam logic [CntW-1:0] CNT_KEY   = 4'd4;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] rx_byte;
  } wsd_item_t;

  typedef struct packed {
    logic [EvW-1:0]   event_res;
    logic [ByteW-1:0] payload_byte;
    logic [OpcW-1:0]  frame_opcode;
    logic             final_fragment;
    logic             last;
    logic [LenW-1:0]  frame_length;
  } wsd_result_t;

endpackage

// File: hw/rtl/wsd_ifs.sv
// Valid/ready channel interfaces for the deframer's input and result sides.
// Depends on nothing; widths match the constants in wsd_pkg.
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  payload_byte;
  logic [3:0]  frame_opcode;
  logic        final_fragment;
  logic        last;
  logic [63:0] frame_length;

  modport source (
    output valid, output event_res, output payload_byte, output frame_opcode,
    output final_fragment, output last, output frame_length, input ready
  );
  modport sink (
    input valid, input event_res, input payload_byte, input frame_opcode,
    input final_fragment, input last, input frame_length, output ready
  );
endinterface

// File: hw/rtl/wsd_in_stage.sv
// Input register of the deframer: holds one accepted transaction.
// Depends on wsd_pkg.
module wsd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wsd_pkg::wsd_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output wsd_pkg::wsd_item_t item
);
  import wsd_pkg::*;

  logic      valid_r;
  wsd_item_t item_r;
  logic      take;

  // The held item is consumed whenever the result side can take a result.
  assign take       = valid_r && advance;
  assign in_ready   = !valid_r || take;
  assign item_valid = take;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// File: hw/rtl/wsd_parser.sv
// Frame header parser and payload unmasker: holds the per-link state and
// computes at most one result per consumed item. Depends on wsd_pkg.
module wsd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  wsd_pkg::wsd_item_t   item,
  output logic                 res_valid,
  output wsd_pkg::wsd_result_t res
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASKKEY, PH_PAYLOAD
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              fin_r, fin_nxt;
  logic [OpcW-1:0]   opc_r, opc_nxt;
  logic [LenW-1:0]   len_r, len_nxt;
  logic [KeyW-1:0]   key_r, key_nxt;
  logic [LenW-1:0]   rem_r, rem_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              closed_r, closed_nxt;

  logic [ByteW-1:0]  b;
  logic [CntW-1:0]   cnt_dec;
  logic [ByteW-1:0]  key_byte;
  logic              fin_byte;

  assign b        = item.rx_byte;
  assign cnt_dec  = cnt_r - CntW'(1);
  assign fin_byte = (rem_r == '0);

  // Key bytes are applied in arrival order, most significant first.
  always_comb begin
    case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    opc_nxt    = opc_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    rem_nxt    = rem_r;
    idx_nxt    = idx_r;
    closed_nxt = closed_r;

    res_valid          = 1'b0;
    res.event_res      = EV_DATA;
    res.payload_byte   = '0;
    res.frame_opcode   = opc_r;
    res.final_fragment = fin_r;
    res.last           = 1'b1;
    res.frame_length   = len_r;

    if (item_valid) begin
      if (item.kind == KIND_REOPEN) begin
        phase_nxt  = PH_HDR0;
        cnt_nxt    = '0;
        fin_nxt    = 1'b0;
        opc_nxt    = '0;
        len_nxt    = '0;
        key_nxt    = '0;
        rem_nxt    = '0;
        idx_nxt    = '0;
        closed_nxt = 1'b0;
      end else if (!closed_r) begin
        unique case (phase_r)
          PH_HDR1: begin
            if (!b[7]) begin
              res_valid        = 1'b1;
              res.event_res    = EV_ERROR;
              res.frame_length = '0;
              closed_nxt       = 1'b1;
              phase_nxt        = PH_HDR0;
            end else begin
              if (b[6:0] <= LEN7_MAX) begin
                len_nxt   = {{(LenW-7){1'b0}}, b[6:0]};
                cnt_nxt   = CNT_KEY;
                phase_nxt = PH_MASKKEY;
              end else begin
                len_nxt   = '0;
                cnt_nxt   = (b[6:0] == LEN7_EXT16) ? CNT_EXT16 : CNT_EXT64;
                phase_nxt = PH_EXTLEN;
              end
              key_nxt = '0;
            end
          end
          PH_EXTLEN: begin
            len_nxt = {len_r[LenW-ByteW-1:0], b};
            cnt_nxt = cnt_dec;
            if (cnt_dec == '0) begin
              cnt_nxt   = CNT_KEY;
              phase_nxt = PH_MASKKEY;
            end
          end
          PH_MASKKEY: begin
            key_nxt = {key_r[KeyW-ByteW-1:0], b};
            cnt_nxt = cnt_dec;
            if (cnt_dec == '0) begin
              idx_nxt = '0;
              rem_nxt = len_r - LenW'(1);
              if (len_r != '0) begin
                phase_nxt = PH_PAYLOAD;
              end else begin
                phase_nxt = PH_HDR0;
                res_valid = 1'b1;
                if (opc_r == OPC_CLOSE) begin
                  res.event_res = EV_CLOSE;
                  closed_nxt    = 1'b1;
                end else begin
                  res.event_res = EV_EMPTY;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            idx_nxt = idx_r + 2'd1;
            rem_nxt = rem_r - LenW'(1);
            if (fin_byte) begin
              phase_nxt = PH_HDR0;
            end
            if (opc_r == OPC_CLOSE) begin
              // Close payload is swallowed; only its end is reported.
              if (fin_byte) begin
                res_valid     = 1'b1;
                res.event_res = EV_CLOSE;
                closed_nxt    = 1'b1;
              end
            end else begin
              res_valid        = 1'b1;
              res.event_res    = EV_DATA;
              res.payload_byte = b ^ key_byte;
              res.last         = fin_byte;
            end
          end
          default: begin
            fin_nxt   = b[7];
            opc_nxt   = b[OpcW-1:0];
            len_nxt   = '0;
            cnt_nxt   = '0;
            idx_nxt   = '0;
            phase_nxt = PH_HDR1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      cnt_r    <= '0;
      fin_r    <= 1'b0;
      opc_r    <= '0;
      len_r    <= '0;
      key_r    <= '0;
      rem_r    <= '0;
      idx_r    <= '0;
      closed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      fin_r    <= fin_nxt;
      opc_r    <= opc_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      rem_r    <= rem_nxt;
      idx_r    <= idx_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

// File: hw/rtl/wsd_out_stage.sv
// Result register of the deframer: holds one result until it is taken.
// Depends on wsd_pkg.
module wsd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  wsd_pkg::wsd_result_t res,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wsd_pkg::wsd_result_t out_res
);
  import wsd_pkg::*;

  logic        valid_r;
  wsd_result_t res_r;

  // A new result may enter when the register is empty or being drained.
  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// File: hw/rtl/websocket_frame_deframer_core.sv
// Top level of the WebSocket frame deframer: input register, parser and
// result register. Depends on wsd_pkg, wsd_ifs, wsd_in_stage, wsd_parser,
// wsd_out_stage.
//
//   channel    direction  transaction carries
//   in_chan    sink       kind, rx_byte
//   out_chan   source     event_res, payload_byte, frame_opcode,
//                         final_fragment, last, frame_length
//
// One input transaction is taken per cycle unless back-pressure on out_chan
// stalls it; its result, if any, passes the input register, then the result register.
// The widest logic per cycle is a 64-bit decrement and compare on the length.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the first header byte with the link open.
// While a result waits in the output register, the next item is held in
// the input register; in_chan.ready stays high as long as out_chan.ready
// is high or the register is empty.
module websocket_frame_deframer_core (
  input logic      clk,
  input logic      rst_n,
  wsd_in_if.sink   in_chan,
  wsd_out_if.source out_chan
);
  import wsd_pkg::*;

  wsd_item_t   in_item;
  wsd_item_t   item;
  logic        item_valid;
  logic        advance;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t out_res;

  assign in_item.kind    = in_chan.kind;
  assign in_item.rx_byte = in_chan.rx_byte;

  wsd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  wsd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .res_valid  (res_valid),
    .res        (res)
  );

  wsd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.event_res      = out_res.event_res;
  assign out_chan.payload_byte   = out_res.payload_byte;
  assign out_chan.frame_opcode   = out_res.frame_opcode;
  assign out_chan.final_fragment = out_res.final_fragment;
  assign out_chan.last           = out_res.last;
  assign out_chan.frame_length   = out_res.frame_length;

endmodule

// File: sim/tb_websocket_frame_deframer_core.sv
// Self-checking testbench for websocket_frame_deframer_core: drives received bytes and
// reopen requests, predicts every deframed event and compares each result transaction.
// Depends on wsd_pkg, wsd_ifs and the deframer RTL.
module tb_websocket_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  typedef enum logic [2:0] {
    AWAIT_HDR0, AWAIT_HDR1, EXT_LEN, MASK_KEY, PAYLOAD
  } parse_phase_t;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned REPORT_LIMIT = 10;

  logic clk;
  logic rst_n;

  wsd_in_if  in_ch ();
  wsd_out_if out_ch ();

  websocket_frame_deframer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Parser image kept in step with the block, one accepted transaction at a time.
  parse_phase_t    rx_phase;
  logic [CntW-1:0] rx_count;
  logic            rx_fin;
  logic [OpcW-1:0] rx_opcode;
  logic [LenW-1:0] rx_length;
  logic [KeyW-1:0] rx_key;
  logic [LenW-1:0] rx_index;
  logic            link_down;

  wsd_result_t awaited_events[$];
  int unsigned mismatch_count = 0;
  int unsigned counted_items = 0;
  bit          steady_in = 1'b0;
  bit          steady_out = 1'b0;

  function automatic void clear_parser();
    rx_phase  = AWAIT_HDR0;
    rx_count  = '0;
    rx_fin    = 1'b0;
    rx_opcode = '0;
    rx_length = '0;
    rx_key    = '0;
    rx_index  = '0;
    link_down = 1'b0;
  endfunction

  function automatic wsd_result_t frame_event(input logic [EvW-1:0] ev,
                                              input logic [ByteW-1:0] data,
                                              input logic fin_byte,
                                              input logic [LenW-1:0] len);
    wsd_result_t r;
    r.event_res      = ev;
    r.payload_byte   = data;
    r.frame_opcode   = rx_opcode;
    r.final_fragment = rx_fin;
    r.last           = fin_byte;
    r.frame_length   = len;
    return r;
  endfunction

  // Returns 1 when the transaction produces a result, which is left in r.
  function automatic bit deframe_byte(input wsd_item_t it, output wsd_result_t r);
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] k;
    logic             end_byte;
    r = '0;
    b = it.rx_byte;
    if (it.kind == KIND_REOPEN) begin
      clear_parser();
      return 1'b0;
    end
    if (link_down) return 1'b0;
    case (rx_phase)
      AWAIT_HDR1: begin
        if (!b[7]) begin
          r = frame_event(EV_ERROR, '0, 1'b1, '0);
          link_down = 1'b1;
          rx_phase = AWAIT_HDR0;
          return 1'b1;
        end
        if (b[6:0] <= LEN7_MAX) begin
          rx_length = LenW'(b[6:0]);
          rx_count = CNT_KEY;
          rx_phase = MASK_KEY;
        end else begin
          rx_length = '0;
          rx_count = (b[6:0] == LEN7_EXT16) ? CNT_EXT16 : CNT_EXT64;
          rx_phase = EXT_LEN;
        end
        rx_key = '0;
        return 1'b0;
      end
      EXT_LEN: begin
        rx_length = {rx_length[LenW-9:0], b};
        rx_count = rx_count - 1'b1;
        if (rx_count == '0) begin
          rx_count = CNT_KEY;
          rx_phase = MASK_KEY;
        end
        return 1'b0;
      end
      MASK_KEY: begin
        rx_key = {rx_key[KeyW-9:0], b};
        rx_count = rx_count - 1'b1;
        if (rx_count != '0) return 1'b0;
        rx_index = '0;
        if (rx_length != '0) begin
          rx_phase = PAYLOAD;
          return 1'b0;
        end
        rx_phase = AWAIT_HDR0;
        if (rx_opcode == OPC_CLOSE) begin
          r = frame_event(EV_CLOSE, '0, 1'b1, rx_length);
          link_down = 1'b1;
        end else begin
          r = frame_event(EV_EMPTY, '0, 1'b1, rx_length);
        end
        return 1'b1;
      end
      PAYLOAD: begin
        // The key is applied most significant byte first, cycling every four bytes.
        k = ByteW'(rx_key >> (8 * (3 - int'(rx_index[1:0]))));
        end_byte = (rx_index >= rx_length - 64'd1);
        rx_index = rx_index + 64'd1;
        if (end_byte) rx_phase = AWAIT_HDR0;
        if (rx_opcode == OPC_CLOSE) begin
          if (!end_byte) return 1'b0;
          r = frame_event(EV_CLOSE, '0, 1'b1, rx_length);
          link_down = 1'b1;
          return 1'b1;
        end
        r = frame_event(EV_DATA, b ^ k, end_byte, rx_length);
        return 1'b1;
      end
      default: begin
        rx_fin = b[7];
        rx_opcode = b[3:0];
        rx_length = '0;
        rx_index = '0;
        rx_count = '0;
        rx_phase = AWAIT_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void note_error(input string what, input wsd_result_t want,
                                     input wsd_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display({"%0t: %s: expected ev=%0d byte=%h opc=%h fin=%b last=%b len=%h,",
                " got ev=%0d byte=%h opc=%h fin=%b last=%b len=%h"},
               $realtime, what, want.event_res, want.payload_byte, want.frame_opcode,
               want.final_fragment, want.last, want.frame_length, got.event_res,
               got.payload_byte, got.frame_opcode, got.final_fragment, got.last,
               got.frame_length);
  endfunction

  task automatic push_item(input logic kind_i, input logic [ByteW-1:0] byte_i);
    int          gap;
    wsd_item_t   it;
    wsd_result_t r;
    gap = steady_in ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind_i;
    in_ch.rx_byte <= byte_i;
    do @(posedge clk); while (!in_ch.ready);
    it.kind = kind_i;
    it.rx_byte = byte_i;
    if (kind_i == KIND_REOPEN || !link_down) counted_items++;
    if (deframe_byte(it, r)) awaited_events.insert(awaited_events.size(), r);
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    push_item(KIND_BYTE, b);
  endtask

  task automatic reopen_link();
    push_item(KIND_REOPEN, ByteW'($urandom));
  endtask

  // Header, optional extended length, then, when masked, the key and n_send random payload bytes.
  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
                            input logic masked, input len_form_t form,
                            input logic [LenW-1:0] len, input logic [KeyW-1:0] key,
                            input int n_send);
    send_byte({fin, rsv, opc});
    case (form)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_EXT16: begin
        send_byte({masked, LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (!masked) return;
    for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    repeat (n_send) send_byte(ByteW'($urandom));
  endtask

  task automatic test_empty_frame();
    send_frame(1'b0, 3'b111, 4'h0, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
  endtask

  task automatic test_unmasked_error();
    send_frame(1'b1, 3'b000, 4'h1, 1'b0, LEN_SHORT, 64'd5, 32'h0, 0);
    send_byte(8'hFF);
    reopen_link();
  endtask

  task automatic test_ext16_payload();
    send_frame(1'b1, 3'b000, 4'hF, 1'b1, LEN_EXT16, 64'd2, 32'hFFFF_0000, 0);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_close_frames();
    send_frame(1'b1, 3'b000, OPC_CLOSE, 1'b1, LEN_SHORT, 64'd1, 32'h1234_5678, 1);
    reopen_link();
    send_frame(1'b1, 3'b010, OPC_CLOSE, 1'b1, LEN_SHORT, 64'd0, 32'h0, 0);
    reopen_link();
  endtask

  task automatic test_ext64_top_bit();
    send_frame(1'b0, 3'b000, 4'hA, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0001,
               32'h0, 2);
    reopen_link();
  endtask

  task automatic test_random_traffic();
    int               pick;
    int               n_send;
    len_form_t        form;
    logic [LenW-1:0]  len;
    logic [OpcW-1:0]  opc;
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) steady_in = ~steady_in;
      if ($urandom_range(0, 4) == 0) steady_out = ~steady_out;
      pick = $urandom_range(0, 99);
      opc = ($urandom_range(0, 4) == 0) ? OPC_CLOSE : OpcW'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          form = LEN_SHORT;
          len = ($urandom_range(0, 9) == 0) ? LenW'(LEN7_MAX) : LenW'($urandom_range(0, 6));
        end
        6, 7, 8: begin
          form = LEN_EXT16;
          len = ($urandom_range(0, 9) == 0) ? 64'hFFFF : LenW'($urandom_range(0, 12));
        end
        default: begin
          form = LEN_EXT64;
          len = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                             : LenW'($urandom_range(0, 12));
        end
      endcase
      if (pick < 85) begin
        n_send = (len > 64'd300) ? $urandom_range(0, 6) : int'(len);
        // Now and then cut a frame short to exercise reopen in mid-payload.
        if (len != 0 && len <= 64'd300 && $urandom_range(0, 19) == 0)
          n_send = $urandom_range(0, int'(len) - 1);
        send_frame(1'($urandom), 3'($urandom), opc, 1'b1, form, len, $urandom, n_send);
      end else if (pick < 92) begin
        send_frame(1'($urandom), 3'($urandom), opc, 1'b0, form, len, $urandom, 0);
      end else begin
        repeat ($urandom_range(1, 8))
          push_item(($urandom_range(0, 3) == 0) ? KIND_REOPEN : KIND_BYTE, ByteW'($urandom));
      end
      if (link_down || rx_phase != AWAIT_HDR0) begin
        repeat ($urandom_range(0, 3)) send_byte(ByteW'($urandom));
        reopen_link();
      end
    end
  endtask

  // Result side: random back-pressure and the field-by-field comparison.
  initial begin
    int          gap;
    wsd_result_t got;
    wsd_result_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = steady_out ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      got.event_res      = out_ch.event_res;
      got.payload_byte   = out_ch.payload_byte;
      got.frame_opcode   = out_ch.frame_opcode;
      got.final_fragment = out_ch.final_fragment;
      got.last           = out_ch.last;
      got.frame_length   = out_ch.frame_length;
      if (awaited_events.size() == 0) begin
        note_error("unexpected result", '0, got);
      end else begin
        want = awaited_events.pop_front();
        if (got.event_res !== want.event_res || got.payload_byte !== want.payload_byte ||
            got.frame_opcode !== want.frame_opcode ||
            got.final_fragment !== want.final_fragment || got.last !== want.last ||
            got.frame_length !== want.frame_length)
          note_error("result mismatch", want, got);
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_BYTE;
    in_ch.rx_byte <= '0;
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_frame();
    test_unmasked_error();
    test_ext16_payload();
    test_close_frames();
    test_ext64_top_bit();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (awaited_events.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
